FILE: hdl/bmprgb_pkg.sv
// ----------------------------------------------------------------------------
// bmprgb_pkg: shared types and constants of the bitmap to RGB565 converter
// Depth codes, register indexes, item codes, the configuration bundle and
// the pixel request passed from the issue stage to the output stage.
// ----------------------------------------------------------------------------
package bmprgb_pkg;

  localparam int COUNT_W = 11;   // pixel count and row width
  localparam int COLOR_W = 16;
  localparam int DATA_W  = 24;
  localparam int CFG_W   = 11;   // widest register
  localparam int CFG_AW  = 2;

  // Depth codes
  localparam logic [2:0] DEPTH_1  = 3'd0;
  localparam logic [2:0] DEPTH_4  = 3'd1;
  localparam logic [2:0] DEPTH_8  = 3'd2;
  localparam logic [2:0] DEPTH_16 = 3'd3;
  localparam logic [2:0] DEPTH_24 = 3'd4;

  // Item codes
  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_PIXEL   = 1'b1;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_DEPTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_NATIVE = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ROW    = 2'd2;

  // Register reset values
  localparam logic [2:0]         DEPTH_RESET  = DEPTH_24;
  localparam logic               NATIVE_RESET = 1'b0;
  localparam logic [COUNT_W-1:0] ROW_RESET    = 11'd1024;

  // Palette word reduction masks
  localparam logic [DATA_W-1:0] BLUE_MASK  = 24'h0000F8;
  localparam logic [DATA_W-1:0] GREEN_MASK = 24'h00FC00;
  localparam logic [DATA_W-1:0] RED_MASK   = 24'hF80000;

  typedef struct packed {
    logic [2:0]         depth;
    logic               native;
    logic [COUNT_W-1:0] row_pixels;
  } cfg_t;

  typedef struct packed {
    logic               use_pal;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               row_end;
  } pix_req_t;

  // Reduce a 0xRRGGBB palette word to 5-6-5.
  function automatic logic [COLOR_W-1:0] reduce_565(input logic [DATA_W-1:0] word);
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] g;
    logic [DATA_W-1:0] b;
    r = word & RED_MASK;
    g = word & GREEN_MASK;
    b = word & BLUE_MASK;
    return {r[23:19], g[15:10], b[7:3]};
  endfunction

endpackage

FILE: hdl/bmprgb_ram.sv
// ----------------------------------------------------------------------------
// bmprgb_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module bmprgb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/bmprgb_issue.sv
// ----------------------------------------------------------------------------
// bmprgb_issue: item register and pixel issue stage
// Holds the accepted item, steps through its pixels one per cycle unless
// stalled, keeps byte assembly and row count, writes palette, issues lookups.
// ----------------------------------------------------------------------------
module bmprgb_issue #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_ROW_PIXELS  = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bmprgb_pkg::cfg_t                   cfg,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               action,
  input  logic                               row_start,
  input  logic [bmprgb_pkg::DATA_W-1:0]      data,
  input  logic [7:0]                         palette_index,
  output logic                               ram_we,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_waddr,
  output logic [bmprgb_pkg::COLOR_W-1:0]     ram_wdata,
  output logic                               ram_re,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_raddr,
  output logic                               req_valid,
  output bmprgb_pkg::pix_req_t               req,
  input  logic                               req_ready
);

  localparam int CW = bmprgb_pkg::COUNT_W;
  localparam int PW = bmprgb_pkg::COLOR_W;

  // Control state
  logic          busy;
  logic [2:0]    sub;
  logic [PW-1:0] pend;
  logic [1:0]    phase;
  logic [CW-1:0] count;

  // Item payload
  logic                          cur_action;
  logic                          cur_rs;
  logic [bmprgb_pkg::DATA_W-1:0] cur_data;
  logic [7:0]                    cur_pidx;

  logic [CW-1:0] lim;
  logic          rs_now;
  logic [CW-1:0] cnt_eff;
  logic [1:0]    phase_eff;
  logic [PW-1:0] pend_eff;
  logic [7:0]    pbyte;
  logic          has_room;
  logic          at_end;
  logic          px;
  logic          lookup;
  logic          last_sub;
  logic [7:0]    pal_idx;
  logic          pal_ok;
  logic [PW-1:0] direct_color;
  logic [1:0]    phase_next;
  logic [PW-1:0] pend_next;
  logic [CW-1:0] count_next;
  logic          emit;
  logic          go;
  logic          done;

  always_comb begin
    if (int'(cfg.row_pixels) > MAX_ROW_PIXELS) begin
      lim = CW'(MAX_ROW_PIXELS);
    end else begin
      lim = cfg.row_pixels;
    end
  end

  assign rs_now    = (cur_action == bmprgb_pkg::ACT_PIXEL) && cur_rs && (sub == 3'd0);
  assign cnt_eff   = rs_now ? '0 : count;
  assign phase_eff = rs_now ? 2'd0 : phase;
  assign pend_eff  = rs_now ? '0 : pend;
  assign pbyte     = cur_data[7:0];
  assign has_room  = cnt_eff < lim;
  assign at_end    = CW'(cnt_eff + 1'b1) == lim;

  always_comb begin
    px           = 1'b0;
    lookup       = 1'b0;
    last_sub     = 1'b1;
    pal_idx      = 8'h00;
    direct_color = '0;
    phase_next   = phase_eff;
    pend_next    = pend_eff;
    if (cur_action == bmprgb_pkg::ACT_PIXEL) begin
      unique case (cfg.depth)
        bmprgb_pkg::DEPTH_1: begin
          lookup   = 1'b1;
          pal_idx  = {7'b0, pbyte[3'd7 - sub]};
          last_sub = (sub == 3'd7);
        end
        bmprgb_pkg::DEPTH_4: begin
          lookup   = 1'b1;
          pal_idx  = sub[0] ? {4'b0, pbyte[3:0]} : {4'b0, pbyte[7:4]};
          last_sub = sub[0];
        end
        bmprgb_pkg::DEPTH_8: begin
          lookup  = 1'b1;
          pal_idx = pbyte;
        end
        bmprgb_pkg::DEPTH_16: begin
          if (phase_eff == 2'd0) begin
            pend_next  = {8'h00, pbyte};
            phase_next = 2'd1;
          end else begin
            px = 1'b1;
            if (cfg.native) begin
              direct_color = {pbyte, pend_eff[7:0]};
            end else begin
              direct_color = {pbyte[6:0], pend_eff[7:5], 1'b0, pend_eff[4:0]};
            end
            pend_next  = '0;
            phase_next = 2'd0;
          end
        end
        bmprgb_pkg::DEPTH_24: begin
          if (phase_eff == 2'd0) begin
            pend_next  = {8'h00, pbyte};
            phase_next = 2'd1;
          end else if (phase_eff == 2'd1) begin
            pend_next  = {pbyte, pend_eff[7:0]};
            phase_next = 2'd2;
          end else begin
            px           = 1'b1;
            direct_color = {pbyte[7:3], pend_eff[15:10], pend_eff[7:3]};
            pend_next    = '0;
            phase_next   = 2'd0;
          end
        end
        default: begin
          px = 1'b0;
        end
      endcase
      if (lookup) begin
        px = 1'b1;
      end
    end
  end

  // An index beyond the palette reads as black.
  assign pal_ok = {1'b0, pal_idx} < 9'(PALETTE_ENTRIES);

  assign emit       = px && has_room;
  assign count_next = emit ? CW'(cnt_eff + 1'b1) : cnt_eff;
  assign go         = busy && (req_ready || !emit);
  // Once the row is full the remaining pixels of a byte are all dropped.
  assign done       = last_sub || !emit || at_end;
  assign item_stall = busy && !(go && done);

  assign ram_we    = go && (cur_action == bmprgb_pkg::ACT_PALETTE) &&
                     ({1'b0, cur_pidx} < 9'(PALETTE_ENTRIES));
  assign ram_waddr = cur_pidx[$clog2(PALETTE_ENTRIES)-1:0];
  assign ram_wdata = bmprgb_pkg::reduce_565(cur_data);
  assign ram_re    = go && emit && lookup && pal_ok;
  assign ram_raddr = pal_idx[$clog2(PALETTE_ENTRIES)-1:0];

  assign req_valid   = go && emit;
  assign req.use_pal = lookup && pal_ok;
  assign req.color   = direct_color;
  assign req.last    = last_sub || at_end;
  assign req.row_end = at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      sub   <= 3'd0;
      pend  <= '0;
      phase <= 2'd0;
      count <= '0;
    end else begin
      if (go && (cur_action == bmprgb_pkg::ACT_PIXEL)) begin
        count <= count_next;
        phase <= phase_next;
        pend  <= pend_next;
      end
      if (go) begin
        sub <= done ? 3'd0 : 3'(sub + 1'b1);
      end
      if (item_valid && !item_stall) begin
        busy <= 1'b1;
        sub  <= 3'd0;
      end else if (go && done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      cur_action <= action;
      cur_rs     <= row_start;
      cur_data   <= data;
      cur_pidx   <= palette_index;
    end
  end

endmodule

FILE: hdl/bmprgb_emit.sv
// ----------------------------------------------------------------------------
// bmprgb_emit: palette read stage and output register
// Holds each request while its palette read completes, merges it with direct
// colours and presents the pixel on the output channel.
// ----------------------------------------------------------------------------
module bmprgb_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  bmprgb_pkg::pix_req_t           req,
  output logic                           req_ready,
  input  logic [bmprgb_pkg::COLOR_W-1:0] ram_q,
  output logic                           pix_valid,
  input  logic                           pix_stall,
  output logic [bmprgb_pkg::COLOR_W-1:0] color,
  output logic                           last,
  output logic                           row_end
);

  logic                 s1_valid;
  bmprgb_pkg::pix_req_t s1;
  logic                 out_adv;

  assign out_adv   = !pix_valid || !pix_stall;
  assign req_ready = !s1_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (out_adv) begin
        pix_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready) begin
      s1 <= req;
    end
    if (out_adv) begin
      color   <= s1.use_pal ? ram_q : s1.color;
      last    <= s1.last;
      row_end <= s1.row_end;
    end
  end

endmodule

FILE: hdl/bmp_pixel_to_rgb565.sv
// ----------------------------------------------------------------------------
// bmp_pixel_to_rgb565: bitmap row bytes to RGB565 pixels
// Palette loading and depth-dependent unpacking of raw bitmap bytes.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the item channel (item_valid / item_stall): either
// a palette write (action low) storing a 0xRRGGBB word, reduced to 5-6-5,
// at palette_index, or a raw pixel byte (action high) in data[7:0], with
// row_start marking the first byte of a row. Pixels leave on the pixel
// channel (pix_valid / pix_stall), each with last on the final pixel of its
// byte and row_end on the final pixel of the row.
// Each pixel goes from the item register through the read stage to the output
// register. Throughput is one pixel per cycle while pix_stall is low, set by
// the single issue stage that steps through the pixels of the held byte:
// eight for a 1-bit byte, two for a 4-bit byte, at most one for any other
// item. Bytes whose pixels fall beyond the row width give none.
// The user must write the configuration port (cfg_we, cfg_addr, cfg_wdata)
// only while idle; the block does not enforce it. Reset clears the pipeline,
// the byte assembly and the row count and restores the register defaults
// (24-bit depth, 555 for 16-bit, 1024 pixels per row); the palette is
// undefined until written. While pix_stall is high the output holds, and the
// block keeps taking items until its stages are full, then raises item_stall.
// ----------------------------------------------------------------------------
module bmp_pixel_to_rgb565 #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_ROW_PIXELS  = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bmprgb_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [bmprgb_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               action,
  input  logic                               row_start,
  input  logic [bmprgb_pkg::DATA_W-1:0]      data,
  input  logic [7:0]                         palette_index,
  output logic                               pix_valid,
  input  logic                               pix_stall,
  output logic [bmprgb_pkg::COLOR_W-1:0]     color,
  output logic                               last,
  output logic                               row_end
);

  localparam int PAW = $clog2(PALETTE_ENTRIES);

  bmprgb_pkg::cfg_t     cfg;
  logic                 ram_we;
  logic [PAW-1:0]       ram_waddr;
  logic [bmprgb_pkg::COLOR_W-1:0] ram_wdata;
  logic                 ram_re;
  logic [PAW-1:0]       ram_raddr;
  logic [bmprgb_pkg::COLOR_W-1:0] ram_q;
  logic                 req_valid;
  bmprgb_pkg::pix_req_t req;
  logic                 req_ready;

  // Configuration registers; writes beyond the register list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth      <= bmprgb_pkg::DEPTH_RESET;
      cfg.native     <= bmprgb_pkg::NATIVE_RESET;
      cfg.row_pixels <= bmprgb_pkg::ROW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bmprgb_pkg::REG_DEPTH:  cfg.depth      <= cfg_wdata[2:0];
        bmprgb_pkg::REG_NATIVE: cfg.native     <= cfg_wdata[0];
        bmprgb_pkg::REG_ROW:    cfg.row_pixels <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Issue stage: holds one item; one pixel request per cycle unless stalled.
  bmprgb_issue #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .MAX_ROW_PIXELS  (MAX_ROW_PIXELS)
  ) u_issue (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .row_start     (row_start),
    .data          (data),
    .palette_index (palette_index),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .req_valid     (req_valid),
    .req           (req),
    .req_ready     (req_ready)
  );

  // Palette store; the read is registered and holds while the read stage
  // is stalled, so the looked-up colour waits with its request.
  bmprgb_ram #(
    .WIDTH (bmprgb_pkg::COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_q)
  );

  // Read stage and output register.
  bmprgb_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .ram_q     (ram_q),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .color     (color),
    .last      (last),
    .row_end   (row_end)
  );

`ifndef SYNTHESIS
  // One item at a time owns the palette, so a write and a lookup never meet.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("palette written and read in the same cycle");

  // The last pixel of a row is always the last pixel of its byte.
  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    pix_valid && row_end |-> last)
    else $error("row_end without last");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("output valid straight after reset");
`endif

endmodule

FILE: bench/tb_bmp_pixel_to_rgb565.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bmp_pixel_to_rgb565: self-checking bench for the bitmap to RGB565 block
// Tries the reset settings, loads the palette, then pushes raw row bytes at
// every pixel depth under several register settings. A behavioural copy of
// the converter runs on each accepted transfer, and every pixel that leaves
// the block is checked field by field against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb_bmp_pixel_to_rgb565;

  // One predicted or observed pixel transfer.
  typedef struct packed {
    logic [bmprgb_pkg::COLOR_W-1:0] color;
    logic                           last;
    logic                           row_end;
  } pixel_t;

  localparam int         MAX_ROW       = 1024;  // saturation point of the row width
  localparam int         SETTLE_CYCLES = 24;    // an 8-pixel byte plus pipeline, with slack
  localparam int         RANDOM_BYTES  = 48;
  localparam int         MAX_REPORTS   = 10;
  localparam logic [2:0] DEPTH_UNUSED  = 3'd7;  // a code with no depth behind it

  // --------------------------------------------------------------------------
  // Signals. Every input of the block starts at a known value.
  // --------------------------------------------------------------------------
  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           cfg_we        = 1'b0;
  logic [bmprgb_pkg::CFG_AW-1:0]  cfg_addr      = '0;
  logic [bmprgb_pkg::CFG_W-1:0]   cfg_wdata     = '0;
  logic                           item_valid    = 1'b0;
  logic                           item_stall;
  logic                           action        = bmprgb_pkg::ACT_PIXEL;
  logic                           row_start     = 1'b0;
  logic [bmprgb_pkg::DATA_W-1:0]  data          = '0;
  logic [7:0]                     palette_index = '0;
  logic                           pix_valid;
  logic                           pix_stall     = 1'b0;
  logic [bmprgb_pkg::COLOR_W-1:0] color;
  logic                           last;
  logic                           row_end;

  bmp_pixel_to_rgb565 dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .action        (action),
    .row_start     (row_start),
    .data          (data),
    .palette_index (palette_index),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .color         (color),
    .last          (last),
    .row_end       (row_end)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioural copy of the converter: palette, byte assembly, row count and
  // the registers as last written. It advances once per accepted transfer.
  // --------------------------------------------------------------------------
  logic [bmprgb_pkg::COLOR_W-1:0] pal_mem    [256];
  bit                             pal_loaded [256];
  logic [15:0]                    asm_bytes      = '0;
  logic [1:0]                     asm_phase      = '0;
  logic [bmprgb_pkg::COUNT_W-1:0] row_count      = '0;
  logic [2:0]                     cur_depth      = bmprgb_pkg::DEPTH_RESET;
  logic                           cur_native     = bmprgb_pkg::NATIVE_RESET;
  logic [bmprgb_pkg::COUNT_W-1:0] cur_row_pixels = bmprgb_pkg::ROW_RESET;

  // Pixels predicted but not yet seen on the output, oldest first.
  pixel_t due_pixels [$];

  int  bytes_sent     = 0;
  int  pal_writes     = 0;
  int  pixels_checked = 0;
  int  mismatches     = 0;
  bit  gaps_on        = 1'b1;
  bit  stalls_on      = 1'b1;
  int  stall_run      = 0;
  int  rx_pick;
  pixel_t want;

  // Works out the pixels that one accepted item produces and queues them.
  function automatic void convert_item(input logic act, input logic rs,
                                       input logic [bmprgb_pkg::DATA_W-1:0] word,
                                       input logic [7:0] idx);
    logic [7:0]                     px;
    logic [bmprgb_pkg::COLOR_W-1:0] cand [8];
    pixel_t                         burst [8];
    int                             ncand;
    int                             nout;
    int                             bits;
    int                             sel;
    int                             lim;
    px    = word[7:0];
    ncand = 0;
    nout  = 0;
    if (act == bmprgb_pkg::ACT_PALETTE) begin
      // A palette write keeps the top bits of each channel and emits nothing;
      // a row start on it is of no consequence.
      pal_mem[idx]    = {word[23:19], word[15:10], word[7:3]};
      pal_loaded[idx] = 1'b1;
      return;
    end
    if (rs) begin
      asm_bytes = '0;
      asm_phase = '0;
      row_count = '0;
    end
    case (cur_depth)
      bmprgb_pkg::DEPTH_1, bmprgb_pkg::DEPTH_4, bmprgb_pkg::DEPTH_8: begin
        // Palette depths: indexes are taken most significant first.
        bits = (cur_depth == bmprgb_pkg::DEPTH_1) ? 1 :
               (cur_depth == bmprgb_pkg::DEPTH_4) ? 4 : 8;
        for (int i = 0; i < 8 / bits; i++) begin
          sel         = (int'(px) >> (8 - bits * (i + 1))) & ((1 << bits) - 1);
          cand[ncand] = pal_mem[sel];
          ncand++;
        end
      end
      bmprgb_pkg::DEPTH_16: begin
        // Low byte first; any non-zero phase completes the pixel, which also
        // covers a switch from 24-bit assembly part way through a pixel.
        if (asm_phase == 2'd0) begin
          asm_bytes = {8'h00, px};
          asm_phase = 2'd1;
        end else begin
          if (cur_native)
            cand[0] = {px, asm_bytes[7:0]};
          else
            cand[0] = {px[6:0], asm_bytes[7:5], 1'b0, asm_bytes[4:0]};
          ncand     = 1;
          asm_bytes = '0;
          asm_phase = '0;
        end
      end
      bmprgb_pkg::DEPTH_24: begin
        // Blue, green, then red completes the pixel.
        if (asm_phase == 2'd0) begin
          asm_bytes = {8'h00, px};
          asm_phase = 2'd1;
        end else if (asm_phase == 2'd1) begin
          asm_bytes = {px, asm_bytes[7:0]};
          asm_phase = 2'd2;
        end else begin
          cand[0]   = {px[7:3], asm_bytes[15:10], asm_bytes[7:3]};
          ncand     = 1;
          asm_bytes = '0;
          asm_phase = '0;
        end
      end
      default: ;
    endcase
    // Only the first pixels of a row up to the (saturated) width get out.
    lim = (int'(cur_row_pixels) > MAX_ROW) ? MAX_ROW : int'(cur_row_pixels);
    for (int k = 0; k < ncand; k++) begin
      if (int'(row_count) < lim) begin
        row_count             = row_count + 1'b1;
        burst[nout].color     = cand[k];
        burst[nout].last      = 1'b0;
        burst[nout].row_end   = (int'(row_count) == lim);
        nout++;
      end
    end
    for (int k = 0; k < nout; k++) begin
      burst[k].last = (k == nout - 1);
      due_pixels.push_back(burst[k]);
    end
  endfunction

  // Gap after a transfer: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!gaps_on)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // --------------------------------------------------------------------------
  // Item channel. Fields are driven at the falling edge and held until the
  // rising edge at which stall is low; the prediction follows that transfer.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic act, input logic rs,
                           input logic [bmprgb_pkg::DATA_W-1:0] word,
                           input logic [7:0] idx);
    int gap;
    @(negedge clk);
    item_valid    <= 1'b1;
    action        <= act;
    row_start     <= rs;
    data          <= word;
    palette_index <= idx;
    @(posedge clk);
    while (item_stall)
      @(posedge clk);
    convert_item(act, rs, word, idx);
    if (act == bmprgb_pkg::ACT_PALETTE)
      pal_writes++;
    else
      bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drops valid, waits for every predicted pixel, then lets the block finish
  // any byte that produces nothing before the registers may be touched.
  task automatic wait_idle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (due_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bmprgb_pkg::CFG_AW-1:0] idx,
                           input logic [bmprgb_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      bmprgb_pkg::REG_DEPTH:  cur_depth      = value[2:0];
      bmprgb_pkg::REG_NATIVE: cur_native     = value[0];
      bmprgb_pkg::REG_ROW:    cur_row_pixels = value[bmprgb_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [2:0] depth, input logic native,
                            input logic [bmprgb_pkg::COUNT_W-1:0] width);
    wait_idle();
    write_reg(bmprgb_pkg::REG_DEPTH, bmprgb_pkg::CFG_W'(depth));
    write_reg(bmprgb_pkg::REG_NATIVE, bmprgb_pkg::CFG_W'(native));
    write_reg(bmprgb_pkg::REG_ROW, width);
  endtask

  // --------------------------------------------------------------------------
  // Pixel channel. The stall is changed at the falling edge in runs of random
  // length; the output is sampled at the rising edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst || !stalls_on) begin
      pix_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 55) begin
        pix_stall <= 1'b0;
        stall_run = $urandom_range(0, 4);
      end else if (rx_pick < 93) begin
        pix_stall <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        pix_stall <= 1'b1;
        stall_run = $urandom_range(6, 25);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall) begin
      if (due_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: pixel with none predicted: color %h last %b row_end %b",
                   $time, color, last, row_end);
      end else begin
        want = due_pixels.pop_front();
        pixels_checked++;
        if (want.color !== color || want.last !== last || want.row_end !== row_end) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: pixel %0d expected color %h last %b row_end %b, got %h %b %b",
                     $time, pixels_checked, want.color, want.last, want.row_end,
                     color, last, row_end);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Registers as left by reset: 24-bit pixels and a full-width row.
  task automatic test_reset_defaults();
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b1, 24'hFFFF00, 8'hFF);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b0, 24'h0000FF, 8'h00);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b0, 24'hAB5580, 8'h5A);
  endtask

  // Fills the entries that 1-bit and 4-bit bytes can reach, with the colour
  // extremes at the bottom. A row start on a palette write is ignored.
  task automatic test_palette_load();
    logic [bmprgb_pkg::DATA_W-1:0] word;
    for (int i = 0; i < 16; i++) begin
      word = (i == 0) ? 24'h000000 : (i == 1) ? 24'hFFFFFF :
             bmprgb_pkg::DATA_W'($urandom);
      send_item(bmprgb_pkg::ACT_PALETTE, i[0], word, 8'(i));
    end
  endtask

  // Palette depths, with the row width saturated, small and one pixel wide.
  task automatic test_palette_depths();
    set_config(bmprgb_pkg::DEPTH_1, 1'b0, 11'd2047);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b1, 24'h00FFA5, 8'h00);
    set_config(bmprgb_pkg::DEPTH_4, 1'b1, 11'd3);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b1, 24'h12340F, 8'hFF);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b0, 24'hFEDCF0, 8'h00);
    set_config(bmprgb_pkg::DEPTH_8, 1'b0, 11'd1);
    send_item(bmprgb_pkg::ACT_PALETTE, 1'b1, 24'hF8FC00, 8'hFF);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b1, 24'h0000FF, 8'h00);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b0, 24'hFFFF00, 8'h00);
  endtask

  // 16-bit as 555 and as native 565, then 24-bit with a one-pixel row.
  task automatic test_wide_depths();
    set_config(bmprgb_pkg::DEPTH_16, 1'b0, 11'd1024);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b1, 24'h0000FF, 8'h00);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b0, 24'hFFFFFF, 8'h00);
    set_config(bmprgb_pkg::DEPTH_16, 1'b1, 11'd1024);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b1, 24'hFFFF00, 8'h00);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b0, 24'h0000FF, 8'h00);
    set_config(bmprgb_pkg::DEPTH_24, 1'b0, 11'd1);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b1, 24'h0000F8, 8'h00);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b0, 24'h0000FC, 8'h00);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b0, 24'h0000F8, 8'h00);
  endtask

  // Bytes that produce nothing: a zero-width row and an unused depth code.
  task automatic test_silent_bytes();
    set_config(bmprgb_pkg::DEPTH_1, 1'b0, 11'd0);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b1, 24'h0000FF, 8'h00);
    set_config(DEPTH_UNUSED, 1'b1, 11'd8);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b1, 24'h000081, 8'h00);
  endtask

  // A depth change between bytes of one pixel: two 24-bit bytes, then the
  // 16-bit path completes the pixel from the held low byte.
  task automatic test_depth_switch();
    set_config(bmprgb_pkg::DEPTH_24, 1'b0, 11'd1024);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b1, 24'h00003C, 8'h00);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b0, 24'h0000C3, 8'h00);
    set_config(bmprgb_pkg::DEPTH_16, 1'b1, 11'd1024);
    send_item(bmprgb_pkg::ACT_PIXEL, 1'b0, 24'h000099, 8'h00);
  endtask

  // --------------------------------------------------------------------------
  // Random rows: each phase picks new settings and a few palette writes, then
  // sends short rows, mostly well formed, now and then without a row start or
  // with a stray byte, and with the odd palette write in the middle.
  // --------------------------------------------------------------------------
  task automatic test_random_rows();
    int                             counted;
    int                             phase_bytes;
    int                             per_px;
    int                             nbytes;
    int                             pick;
    bit                             open_row;
    logic [2:0]                     depth;
    logic [bmprgb_pkg::COUNT_W-1:0] width;
    logic [bmprgb_pkg::DATA_W-1:0]  word;
    counted = 0;
    while (counted < RANDOM_BYTES) begin
      depth = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(5, 7))
                                           : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
        0:       width = 11'd0;
        1:       width = 11'd1024;
        2:       width = 11'd2047;
        3:       width = bmprgb_pkg::COUNT_W'($urandom_range(0, 2047));
        default: width = bmprgb_pkg::COUNT_W'($urandom_range(1, 12));
      endcase
      set_config(depth, 1'($urandom), width);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4))
        send_item(bmprgb_pkg::ACT_PALETTE, 1'($urandom),
                  bmprgb_pkg::DATA_W'($urandom), 8'($urandom));
      phase_bytes = 0;
      while (phase_bytes < 12) begin
        per_px   = (cur_depth == bmprgb_pkg::DEPTH_24) ? 3 :
                   (cur_depth == bmprgb_pkg::DEPTH_16) ? 2 : 1;
        nbytes   = per_px * $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0)
          nbytes += $urandom_range(1, 2);
        open_row = ($urandom_range(0, 9) != 0);
        for (int b = 0; b < nbytes; b++) begin
          if ($urandom_range(0, 19) == 0)
            send_item(bmprgb_pkg::ACT_PALETTE, 1'($urandom),
                      bmprgb_pkg::DATA_W'($urandom), 8'($urandom));
          word = bmprgb_pkg::DATA_W'($urandom);
          // 8-bit indexes only ever point at entries that hold a colour.
          if (cur_depth == bmprgb_pkg::DEPTH_8) begin
            pick = $urandom_range(0, 255);
            while (!pal_loaded[pick])
              pick = $urandom_range(0, 255);
            word[7:0] = 8'(pick);
          end
          send_item(bmprgb_pkg::ACT_PIXEL, (b == 0) && open_row, word, 8'($urandom));
          phase_bytes++;
          if (cur_depth <= bmprgb_pkg::DEPTH_24)
            counted++;
        end
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_palette_load();
    test_palette_depths();
    test_wide_depths();
    test_silent_bytes();
    test_depth_switch();
    test_random_rows();

    wait_idle();
    $display("Sent %0d pixel bytes and %0d palette writes across all depths and widths.",
             bytes_sent, pal_writes);
    $display("Checked %0d pixels, %0d mismatches.", pixels_checked, mismatches);
    if (mismatches == 0 && due_pixels.size() == 0)
      $display("PASS bmp_pixel_to_rgb565");
    else
      $display("FAIL bmp_pixel_to_rgb565");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Run timed out with %0d pixels outstanding.", due_pixels.size());
    $display("FAIL bmp_pixel_to_rgb565");
    $finish;
  end

endmodule
